// ----- rtl/vr2d_pkg.sv -----
// ----------------------------------------------------------------------------
// vr2d_pkg - shared constants for the 2D vector rotator
// Arctangent table, gain constant and fixed internal widths.
// ----------------------------------------------------------------------------
package vr2d_pkg;

   // extra fraction bits carried through the micro-rotations
   localparam int Guard = 16;
   // binary angle width, 65536 units per turn
   localparam int AngleWidth = 16;
   // residual angle width, units of 2^-32 turn
   localparam int ZWidth = 33;
   // gain constant width as a signed operand
   localparam int GainWidth = 31;
   // prescale product is shifted right by this much
   localparam int PreShift = 30 - Guard;
   localparam int AtanDepth = 32;
   localparam int AtanIdxWidth = $clog2(AtanDepth);

   typedef logic signed [ZWidth-1:0] zang_type;
   typedef logic [31:0] atan_type;

   // 0.60725293501 in Q0.30, limit of the inverse CORDIC gain
   localparam logic signed [GainWidth-1:0] GainQ30 = 31'sd652032874;

   // round(atan(2^-i) * 2^32 / (2*pi))
   localparam atan_type AtanTab [AtanDepth] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   // arctangent step as a residual-angle value
   function automatic zang_type atan_at(input logic [AtanIdxWidth-1:0] idx);
      zang_type res;
      res = zang_type'({1'b0, AtanTab[idx]});
      return res;
   endfunction

endpackage

// ----- rtl/vector_rotate_2d.sv -----
// ----------------------------------------------------------------------------
// vector_rotate_2d - pipelined CORDIC rotation of a 2D point
// Rotates (x, y) by a binary angle with gain compensation and saturation.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  req_    | in  | tdata: x_in, y_in, turn_angle
//  rsp_    | out | tdata: x_out, y_out; tuser: clipped
//
//  Throughput: one beat per cycle. Registers in order: angle fold, gain
//  multiply, prescale round, one register per micro-rotation, output round
//  and clamp.
//  Stalls: while rsp_tvalid is high and rsp_tready low the whole pipe holds;
//  req_tready drops in the same cycle, so no beat is lost or repeated.
//  Reset: clears the valid bits only; the data registers keep garbage.
//
module vector_rotate_2d #(
   parameter int COORD_WIDTH    = 16,
   parameter int ROTATION_STEPS = 16,
   localparam int ReqDataWidth  = ((2 * COORD_WIDTH + vr2d_pkg::AngleWidth + 7) / 8) * 8,
   localparam int RspDataWidth  = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   // request stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,  // x_in, y_in, turn_angle (low to high)
   // response stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,  // x_out, y_out (low to high)
   output logic [0:0]              rsp_tuser   // clipped
);

   localparam int W   = COORD_WIDTH;
   localparam int S   = ROTATION_STEPS;
   localparam int ZW  = vr2d_pkg::ZWidth;
   localparam int FW  = W + 1;                          // folded coordinate
   localparam int PW  = FW + vr2d_pkg::GainWidth;        // prescale product
   localparam int IW  = W + vr2d_pkg::Guard + 3;         // rotation datapath
   localparam int AW  = vr2d_pkg::AngleWidth;

   localparam logic signed [PW-1:0] PreHalf = PW'(64'sd1 <<< (vr2d_pkg::PreShift - 1));
   localparam logic signed [IW-1:0] OutHalf = IW'(64'sd1 <<< (vr2d_pkg::Guard - 1));
   localparam logic signed [IW-1:0] CoordMax = IW'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [IW-1:0] CoordMin = IW'(-(64'sd1 <<< (W - 1)));

   // global advance: the pipe moves unless a finished beat is waiting
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // ---------------------------------------------------------------------
   // Stage 1: fold the angle into [-1/4, +1/4) turn by a half-turn flip
   // ---------------------------------------------------------------------
   logic signed [W-1:0]  req_x, req_y;
   logic [AW-1:0]        req_ang;
   logic                 flip;
   logic [AW-1:0]        ang_fold;
   logic signed [FW-1:0] fx_in, fy_in;
   vr2d_pkg::zang_type   fz_in;

   assign req_x   = signed'(req_tdata[W-1:0]);
   assign req_y   = signed'(req_tdata[2*W-1:W]);
   assign req_ang = req_tdata[2*W+AW-1:2*W];

   // second and third quadrant: negate the point, add a half turn
   assign flip     = req_ang[AW-1] ^ req_ang[AW-2];
   assign ang_fold = {req_ang[AW-1] ^ flip, req_ang[AW-2:0]};
   assign fx_in    = flip ? -FW'(req_x) : FW'(req_x);
   assign fy_in    = flip ? -FW'(req_y) : FW'(req_y);
   assign fz_in    = ZW'(signed'(ang_fold)) <<< 16;

   logic signed [FW-1:0] fx_ff, fy_ff;
   vr2d_pkg::zang_type   fz_ff;
   logic                 fvld_ff;

   // ---------------------------------------------------------------------
   // Stage 2: multiply by the gain constant
   // ---------------------------------------------------------------------
   logic signed [PW-1:0] px_in, py_in;
   logic signed [PW-1:0] px_ff, py_ff;
   vr2d_pkg::zang_type   pz_ff;
   logic                 pvld_ff;

   assign px_in = fx_ff * vr2d_pkg::GainQ30;
   assign py_in = fy_ff * vr2d_pkg::GainQ30;

   // ---------------------------------------------------------------------
   // Stage 3: round half up, keeping Guard fraction bits
   // ---------------------------------------------------------------------
   logic signed [PW-1:0] px_rnd, py_rnd;
   logic signed [IW-1:0] x0_in, y0_in;

   assign px_rnd = (px_ff + PreHalf) >>> vr2d_pkg::PreShift;
   assign py_rnd = (py_ff + PreHalf) >>> vr2d_pkg::PreShift;
   assign x0_in  = IW'(px_rnd);
   assign y0_in  = IW'(py_rnd);

   // ---------------------------------------------------------------------
   // Micro-rotation stages: entry 0 is the prescaled point, entry k+1 the
   // result of rotation step k
   // ---------------------------------------------------------------------
   logic signed [IW-1:0] x_ff   [S+1];
   logic signed [IW-1:0] y_ff   [S+1];
   vr2d_pkg::zang_type   z_ff   [S+1];
   logic                 vld_ff [S+1];

   logic signed [IW-1:0] x_in   [S+1];
   logic signed [IW-1:0] y_in   [S+1];
   vr2d_pkg::zang_type   z_in   [S+1];

   assign x_in[0] = x0_in;
   assign y_in[0] = y0_in;
   assign z_in[0] = pz_ff;

   for (genvar i = 0; i < S; i++) begin : g_step
      logic signed [IW-1:0] xs, ys;
      vr2d_pkg::zang_type   at;
      logic                 pos;

      assign xs  = x_ff[i] >>> i;
      assign ys  = y_ff[i] >>> i;
      assign at  = vr2d_pkg::atan_at(vr2d_pkg::AtanIdxWidth'(i));
      assign pos = !z_ff[i][ZW-1];

      // rotate toward zero residual angle
      assign x_in[i+1] = pos ? (x_ff[i] - ys) : (x_ff[i] + ys);
      assign y_in[i+1] = pos ? (y_ff[i] + xs) : (y_ff[i] - xs);
      assign z_in[i+1] = pos ? (z_ff[i] - at) : (z_ff[i] + at);
   end

   // ---------------------------------------------------------------------
   // Output stage: drop the guard bits with rounding, clamp to range
   // ---------------------------------------------------------------------
   logic signed [IW-1:0] xo_rnd, yo_rnd;
   logic                 x_hi, x_lo, y_hi, y_lo;
   logic signed [W-1:0]  xo_in, yo_in;
   logic                 clip_in;

   assign xo_rnd = (x_ff[S] + OutHalf) >>> vr2d_pkg::Guard;
   assign yo_rnd = (y_ff[S] + OutHalf) >>> vr2d_pkg::Guard;
   assign x_hi   = xo_rnd > CoordMax;
   assign x_lo   = xo_rnd < CoordMin;
   assign y_hi   = yo_rnd > CoordMax;
   assign y_lo   = yo_rnd < CoordMin;

   always_comb begin
      priority if (x_hi) begin
         xo_in = W'(CoordMax);
      end else if (x_lo) begin
         xo_in = W'(CoordMin);
      end else begin
         xo_in = W'(xo_rnd);
      end
      priority if (y_hi) begin
         yo_in = W'(CoordMax);
      end else if (y_lo) begin
         yo_in = W'(CoordMin);
      end else begin
         yo_in = W'(yo_rnd);
      end
   end

   assign clip_in = x_hi || x_lo || y_hi || y_lo;

   logic signed [W-1:0] xo_ff, yo_ff;
   logic                clip_ff;
   logic                ovld_ff;

   // ---------------------------------------------------------------------
   // Pipeline registers: hold everything on a stall
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fvld_ff <= 1'b0;
         pvld_ff <= 1'b0;
         ovld_ff <= 1'b0;
         for (int k = 0; k <= S; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         fvld_ff   <= req_tvalid;
         pvld_ff   <= fvld_ff;
         vld_ff[0] <= pvld_ff;
         for (int k = 1; k <= S; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         ovld_ff <= vld_ff[S];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         fz_ff <= fz_in;
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= fz_ff;
         for (int k = 0; k <= S; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
         xo_ff   <= xo_in;
         yo_ff   <= yo_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_tvalid   = ovld_ff;
   assign rsp_tdata    = RspDataWidth'({yo_ff, xo_ff});
   assign rsp_tuser[0] = clip_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // folded residual angle lies within a quarter turn either side of zero
   a_fold_range : assert property (@(posedge clock) disable iff (reset)
      fvld_ff |-> (fz_ff[ZW-1:30] == 3'b000) || (fz_ff[ZW-1:30] == 3'b111))
      else $error("folded angle outside a quarter turn");

   // last rotation-stage valid bit takes the bit before it on each advance
   a_valid_shift : assert property (@(posedge clock) disable iff (reset)
      advance |=> (vld_ff[S] == $past(vld_ff[S-1])))
      else $error("valid bit lost or repeated in rotation stages");

   // clipped beat carries a coordinate at a range limit
   a_clip_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && clip_ff) |->
         (xo_ff == W'(CoordMax)) || (xo_ff == W'(CoordMin)) ||
         (yo_ff == W'(CoordMax)) || (yo_ff == W'(CoordMin)))
      else $error("clipped set without a saturated coordinate");

   // coordinates strictly inside the range never flag clipping
   a_no_false_clip : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (xo_ff != W'(CoordMax)) && (xo_ff != W'(CoordMin)) &&
       (yo_ff != W'(CoordMax)) && (yo_ff != W'(CoordMin))) |-> !clip_ff)
      else $error("clipped set on an in-range result");

endmodule
